>>> rtl/unv_pkg.sv
// Package for the unit normal block: widths, path codes and the item passed
// from the front part to the back part. No dependencies.
package unv_pkg;

	localparam int COMP_WIDTH    = 32;
	localparam int OUT_FRAC_BITS = 30;
	localparam int IN_W          = 32;
	localparam int OUT_W         = 32;
	localparam int C_W           = 64;
	localparam int HALF_W        = C_W / 2;
	localparam int SQ_W          = 2 * C_W;
	localparam int SUM_W         = SQ_W + 2;
	localparam int R_SHIFT       = 2 * OUT_FRAC_BITS + 2;
	localparam int F_W           = SQ_W + R_SHIFT + 4;
	localparam int Q_W           = OUT_FRAC_BITS + 1;
	localparam int QDEPTH        = 4;
	localparam int QPTR_W        = 2;
	localparam int PATH_W        = 2;

	localparam logic [PATH_W-1:0] PATH_DIRECT = 2'd0;
	localparam logic [PATH_W-1:0] PATH_XAXIS  = 2'd1;
	localparam logic [PATH_W-1:0] PATH_XZ     = 2'd2;
	localparam logic [PATH_W-1:0] PATH_ZERO   = 2'd3;

	typedef logic signed [C_W-1:0]          comp_t;
	typedef logic signed [COMP_WIDTH-1:0]   elem_t;
	typedef logic signed [2*COMP_WIDTH-1:0] prod_t;

	typedef struct packed {
		comp_t             cx;
		comp_t             cy;
		comp_t             cz;
		logic [PATH_W-1:0] path;
	} job_t;

endpackage

>>> rtl/unv_in_if.sv
// Input channel of the unit normal block: two vectors in signed Q15.16.
// Depends on nothing.
interface unv_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ax;
	logic signed [31:0] ay;
	logic signed [31:0] az;
	logic signed [31:0] bx;
	logic signed [31:0] by_comp;
	logic signed [31:0] bz;

	modport source (output valid, ax, ay, az, bx, by_comp, bz, input ready);
	modport sink   (input valid, ax, ay, az, bx, by_comp, bz, output ready);
endinterface

>>> rtl/unv_out_if.sv
// Output channel of the unit normal block: normal in signed Q1.30 and path code.
// Depends on nothing.
interface unv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] nx;
	logic signed [31:0] ny;
	logic signed [31:0] nz;
	logic [1:0]         path;

	modport source (output valid, nx, ny, nz, path, input ready);
	modport sink   (input valid, nx, ny, nz, path, output ready);
endinterface

>>> rtl/unv_front.sv
// Front part: cross product, squared lengths and choice of fallback path.
// Depends on unv_pkg and unv_in_if.
module unv_front import unv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	unv_in_if.sink     vecs,
	output logic       job_valid,
	input  logic       job_ready,
	output job_t       job
);

	logic  en;
	elem_t a [3];
	elem_t b [3];

	logic  v_s1, v_s2, v_s3;
	elem_t a_s1 [3];
	elem_t b_s1 [3];
	prod_t p_s1 [6];
	prod_t sa_s1 [3];
	prod_t sb_s1 [3];

	elem_t          a_s2 [3];
	elem_t          b_s2 [3];
	comp_t          c_s2 [3];
	logic [C_W-1:0] la_s2, lb_s2;

	job_t  job_s3;
	job_t  job_d;
	comp_t lx, ly, lz;
	logic  cz, nz1, nz2;

	assign en         = !(v_s3 && !job_ready);
	assign vecs.ready = en;
	assign job_valid  = v_s3;
	assign job        = job_s3;

	assign a[0] = $signed(vecs.ax[COMP_WIDTH-1:0]);
	assign a[1] = $signed(vecs.ay[COMP_WIDTH-1:0]);
	assign a[2] = $signed(vecs.az[COMP_WIDTH-1:0]);
	assign b[0] = $signed(vecs.bx[COMP_WIDTH-1:0]);
	assign b[1] = $signed(vecs.by_comp[COMP_WIDTH-1:0]);
	assign b[2] = $signed(vecs.bz[COMP_WIDTH-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vecs.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= a[i];
				b_s1[i]  <= b[i];
				sa_s1[i] <= a[i] * a[i];
				sb_s1[i] <= b[i] * b[i];
			end
			p_s1[0] <= a[1] * b[2];
			p_s1[1] <= a[2] * b[1];
			p_s1[2] <= a[2] * b[0];
			p_s1[3] <= a[0] * b[2];
			p_s1[4] <= a[0] * b[1];
			p_s1[5] <= a[1] * b[0];

			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2[0] <= comp_t'(p_s1[0]) - comp_t'(p_s1[1]);
			c_s2[1] <= comp_t'(p_s1[2]) - comp_t'(p_s1[3]);
			c_s2[2] <= comp_t'(p_s1[4]) - comp_t'(p_s1[5]);
			la_s2   <= comp_t'(sa_s1[0]) + comp_t'(sa_s1[1]) + comp_t'(sa_s1[2]);
			lb_s2   <= comp_t'(sb_s1[0]) + comp_t'(sb_s1[1]) + comp_t'(sb_s1[2]);

			job_s3 <= job_d;
		end
	end

	// pick the longer vector, B on ties, then the first nonzero candidate
	always_comb begin
		if (la_s2 > lb_s2) begin
			lx = comp_t'(a_s2[0]);
			ly = comp_t'(a_s2[1]);
			lz = comp_t'(a_s2[2]);
		end else begin
			lx = comp_t'(b_s2[0]);
			ly = comp_t'(b_s2[1]);
			lz = comp_t'(b_s2[2]);
		end
		cz  = (c_s2[0] == '0) && (c_s2[1] == '0) && (c_s2[2] == '0);
		nz1 = (ly != '0) || (lz != '0);
		nz2 = (ly != '0) || (lz != lx);
		if (!cz) begin
			job_d = '{cx: c_s2[0], cy: c_s2[1], cz: c_s2[2], path: PATH_DIRECT};
		end else if (nz1) begin
			job_d = '{cx: '0, cy: lz, cz: -ly, path: PATH_XAXIS};
		end else if (nz2) begin
			job_d = '{cx: ly, cy: lz - lx, cz: -ly, path: PATH_XZ};
		end else begin
			job_d = '{cx: '0, cy: '0, cz: '0, path: PATH_ZERO};
		end
	end

endmodule

>>> rtl/unv_queue.sv
// Short queue between the front and back parts.
// Depends on unv_pkg.
module unv_queue import unv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push, pop;

	assign push_ready = cnt_q != QDEPTH[QPTR_W:0];
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> rtl/unv_back.sv
// Back part: squared length, digit-by-digit rounded scaling, sign and output register.
// Depends on unv_pkg and unv_out_if.
module unv_back import unv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	output logic       job_ready,
	input  job_t       job,
	unv_out_if.source  norm
);

	localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) <<< OUT_FRAC_BITS;

	logic en;
	comp_t c [3];

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [PATH_W-1:0]   path_s1, path_s2, path_s3, path_s4;
	logic [2:0]          neg_s1, neg_s2, neg_s3, neg_s4;
	logic [C_W-1:0]      mag_s1 [3];
	logic [2*HALF_W-1:0] hh_s2 [3];
	logic [2*HALF_W-1:0] hl_s2 [3];
	logic [2*HALF_W-1:0] ll_s2 [3];
	logic [SQ_W-1:0]     sq_s3 [3];
	logic [SQ_W-1:0]     sq_s4 [3];
	logic [SUM_W-1:0]    s_s4;

	logic [Q_W:0]            v_it;
	logic [PATH_W-1:0]       path_it [Q_W+1];
	logic [2:0]              neg_it  [Q_W+1];
	logic [SUM_W-1:0]        s_it    [Q_W+1];
	logic signed [F_W-1:0]   f_it    [Q_W+1][3];
	logic signed [F_W-1:0]   g_it    [Q_W+1][3];
	logic [Q_W-1:0]          q_it    [Q_W+1][3];
	logic signed [F_W-1:0]   s4_ext;

	assign en        = !norm.valid || norm.ready;
	assign job_ready = en;
	assign c[0]      = job.cx;
	assign c[1]      = job.cy;
	assign c[2]      = job.cz;
	assign s4_ext    = $signed({{(F_W-SUM_W){1'b0}}, s_s4});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_it       <= '0;
			norm.valid <= 1'b0;
		end else if (en) begin
			v_s1       <= job_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_it       <= {v_it[Q_W-1:0], v_s4};
			norm.valid <= v_it[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			path_s1 <= job.path;
			path_s2 <= path_s1;
			path_s3 <= path_s2;
			path_s4 <= path_s3;
			neg_s2  <= neg_s1;
			neg_s3  <= neg_s2;
			neg_s4  <= neg_s3;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= c[i][C_W-1];
				mag_s1[i] <= c[i][C_W-1] ? -c[i] : c[i];
				hh_s2[i]  <= mag_s1[i][C_W-1:HALF_W] * mag_s1[i][C_W-1:HALF_W];
				hl_s2[i]  <= mag_s1[i][C_W-1:HALF_W] * mag_s1[i][HALF_W-1:0];
				ll_s2[i]  <= mag_s1[i][HALF_W-1:0] * mag_s1[i][HALF_W-1:0];
				sq_s3[i]  <= {hh_s2[i], ll_s2[i]} + (SQ_W'({hl_s2[i], 1'b0}) << HALF_W);
				sq_s4[i]  <= sq_s3[i];
			end
			s_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);

			path_it[0] <= path_s4;
			neg_it[0]  <= neg_s4;
			s_it[0]    <= s_s4;
			for (int i = 0; i < 3; i++) begin
				f_it[0][i] <= ($signed({{(F_W-SQ_W){1'b0}}, sq_s4[i]}) <<< R_SHIFT) - s4_ext;
				g_it[0][i] <= -s4_ext;
				q_it[0][i] <= '0;
			end
		end
	end

	// one quotient digit per stage, most significant first
	for (genvar j = 1; j <= Q_W; j++) begin : g_digit
		localparam int B = Q_W - j;
		logic signed [F_W-1:0] s_ext;
		assign s_ext = $signed({{(F_W-SUM_W){1'b0}}, s_it[j-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				path_it[j] <= path_it[j-1];
				neg_it[j]  <= neg_it[j-1];
				s_it[j]    <= s_it[j-1];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_comp
			logic signed [F_W-1:0] trial;
			logic                  ok;
			assign trial = f_it[j-1][i] - (g_it[j-1][i] <<< (B + 2)) - (s_ext <<< (2 * B + 2));
			assign ok    = !trial[F_W-1];

			always_ff @(posedge clk) begin
				if (en) begin
					f_it[j][i] <= ok ? trial : f_it[j-1][i];
					g_it[j][i] <= ok ? g_it[j-1][i] + (s_ext <<< (B + 1)) : g_it[j-1][i];
					q_it[j][i] <= q_it[j-1][i] | (Q_W'(ok) << B);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm.path <= path_it[Q_W];
			if (path_it[Q_W] == PATH_ZERO) begin
				norm.nx <= '0;
				norm.ny <= '0;
				norm.nz <= '0;
			end else begin
				norm.nx <= neg_it[Q_W][0] ? -OUT_W'(q_it[Q_W][0]) : OUT_W'(q_it[Q_W][0]);
				norm.ny <= neg_it[Q_W][1] ? -OUT_W'(q_it[Q_W][1]) : OUT_W'(q_it[Q_W][1]);
				norm.nz <= neg_it[Q_W][2] ? -OUT_W'(q_it[Q_W][2]) : OUT_W'(q_it[Q_W][2]);
			end
		end
	end

	a_zero_path: assert property (@(posedge clk) disable iff (!arst_n)
		norm.valid && norm.path == PATH_ZERO |-> norm.nx == '0 && norm.ny == '0 && norm.nz == '0)
		else $error("zero path with nonzero normal");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm.valid |-> norm.nx <= ONE && norm.nx >= -ONE && norm.ny <= ONE
			&& norm.ny >= -ONE && norm.nz <= ONE && norm.nz >= -ONE)
		else $error("normal component beyond one");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		norm.valid && norm.path != PATH_ZERO |-> norm.nx != '0 || norm.ny != '0 || norm.nz != '0)
		else $error("nonzero path with zero normal");

endmodule

>>> rtl/unit_normal_of_two_vectors.sv
// Top level of the unit normal block: front part, queue and back part.
// Depends on unv_pkg, unv_in_if, unv_out_if, unv_front, unv_queue, unv_back.
//
// vecs carries vectors A and B (signed Q15.16); a transfer happens when
// valid and ready are both high. norm returns one item per input: the unit
// normal of A x B in signed Q1.30, rounded to nearest, and a path code for
// the fallback taken when the cross product is zero.
// The item passes 41 register stages, and the transfer itself loads the
// first: three front stages, one queue slot, four stages of squaring and
// summing, one set-up stage, 31 stages that each settle one quotient bit
// of every component, and the output register.
// Throughput is one item per cycle while norm.ready stays high; the digit
// pipeline takes a new item in every cycle it advances.
// Reset clears every valid flag and the queue; the block is empty after it.
// When the receiver holds norm.ready low while norm.valid is high the back
// part holds, the queue fills, and vecs.ready drops once the queue is full
// and the front part's last stage holds an item.
module unit_normal_of_two_vectors import unv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	unv_in_if.sink     vecs,
	unv_out_if.source  norm
);

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	job_t fq_job, qb_job;

	unv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vecs      (vecs),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	unv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_job)
	);

	unv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.norm      (norm)
	);

endmodule
